// ===== hdl/qalu_pkg.sv =====
// Shared definitions for the quaternion ALU: widths, opcodes, status codes,
// lane sign tables and the saturating narrow function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qalu_pkg;

  // Component format
  localparam int FRAC_BITS  = 16;
  localparam int COMP_WIDTH = 32;
  localparam int IO_W       = 32;
  localparam int SCALAR_W   = 48;

  // Derived widths
  localparam int CW    = COMP_WIDTH;
  localparam int STEPS = CW + 1;                 // quotient / root bits
  localparam int SQ_W  = 2 * CW;                 // square of a component
  localparam int P_W   = 2 * CW + 1;             // signed lane product
  localparam int ACC_W = 2 * CW + 2;             // signed sum of four products
  localparam int MAG_W = 2 * CW + 1;             // magnitude of that sum
  localparam int D_W   = 2 * CW + 1;             // squared norm of b
  localparam int DEN_W = D_W + 1;                // doubled norm (divisor)
  localparam int NUM_W = MAG_W + FRAC_BITS + 2;  // rounded dividend
  localparam int MR_W  = MAG_W + 1 - FRAC_BITS;  // product after rounding shift
  localparam int NAR_W = (MR_W > STEPS) ? MR_W : STEPS;
  localparam int T_W   = 2 * STEPS;              // root trial value
  localparam int LAT   = STEPS + 8;              // stages from input register to lane result

  localparam logic [SCALAR_W-1:0] SCALAR_MAX = '1;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_CONJ  = 3'd4,
    CMD_SQMAG = 3'd5,
    CMD_MAG   = 3'd6
  } qalu_cmd_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_SAT = 2'd2
  } qalu_status_t;

  typedef logic signed [CW-1:0] qalu_comp_t;

  typedef struct packed {
    logic          sat;
    logic [CW-1:0] val;
  } qalu_nar_t;

  typedef struct packed {
    logic          sat;
    logic          dz;
    logic [CW-1:0] val;
  } qalu_lane_res_t;

  // Per-lane subtract masks: bit k set means term k enters negated
  typedef struct packed {
    logic [3:0] mul_neg;
    logic [3:0] div_neg;
    logic       conj_neg;
  } qalu_lane_cfg_t;

  localparam qalu_lane_cfg_t LANE_CFG [4] = '{
    '{mul_neg: 4'b1110, div_neg: 4'b0000, conj_neg: 1'b0},
    '{mul_neg: 4'b1000, div_neg: 4'b0101, conj_neg: 1'b1},
    '{mul_neg: 4'b0010, div_neg: 4'b1001, conj_neg: 1'b1},
    '{mul_neg: 4'b0100, div_neg: 4'b0011, conj_neg: 1'b1}
  };

  // Clamp a sign and magnitude to the component range
  function automatic qalu_nar_t narrow(input logic [NAR_W-1:0] mag, input logic neg);
    qalu_nar_t        res;
    logic [NAR_W-1:0] lim;
    lim = NAR_W'(1) << (CW - 1);
    if (!neg) lim = lim - NAR_W'(1);
    res.sat = (mag > lim);
    res.val = res.sat ? lim[CW-1:0] : mag[CW-1:0];
    if (neg) res.val = -res.val;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/qalu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on qalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qalu_div (
  input  wire logic                        clk,
  input  wire logic [qalu_pkg::DEN_W-1:0]  rem_i,
  input  wire logic [qalu_pkg::STEPS-1:0]  low_i,
  input  wire logic [qalu_pkg::DEN_W-1:0]  den_i,
  output logic      [qalu_pkg::STEPS-1:0]  q_o
);
  import qalu_pkg::*;

  logic [DEN_W-1:0] rem_r [STEPS];
  logic [STEPS-1:0] low_r [STEPS];
  logic [DEN_W-1:0] den_r [STEPS];
  logic [STEPS-1:0] q_r   [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [DEN_W-1:0] rem_p;
    logic [DEN_W-1:0] den_p;
    logic [STEPS-1:0] low_p;
    logic [STEPS-1:0] q_p;
    logic [DEN_W:0]   sh;
    logic             take;

    if (j == 0) begin : g_first
      assign rem_p = rem_i;
      assign den_p = den_i;
      assign low_p = low_i;
      assign q_p   = '0;
    end else begin : g_next
      assign rem_p = rem_r[j-1];
      assign den_p = den_r[j-1];
      assign low_p = low_r[j-1];
      assign q_p   = q_r[j-1];
    end

    // Bring down the next dividend bit and trial-subtract
    assign sh   = {rem_p, low_p[STEPS-1-j]};
    assign take = (sh >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      rem_r[j] <= take ? DEN_W'(sh - {1'b0, den_p}) : sh[DEN_W-1:0];
      den_r[j] <= den_p;
      low_r[j] <= low_p;
      q_r[j]   <= {q_p[STEPS-2:0], take};
    end
  end

  assign q_o = q_r[STEPS-1];

endmodule

`default_nettype wire

// ===== hdl/qalu_lane.sv =====
// One component lane: four products, signed sum, rounding, division and
// final clamp for one result component. Depends on qalu_pkg and qalu_div.
`timescale 1ns / 1ps
`default_nettype none

module qalu_lane (
  input  wire logic                          clk,
  input  wire qalu_pkg::qalu_cmd_t           cmd_i,
  input  wire qalu_pkg::qalu_lane_cfg_t      cfg_i,
  input  wire qalu_pkg::qalu_comp_t          a_i [4],
  input  wire qalu_pkg::qalu_comp_t          b_i [4],
  input  wire qalu_pkg::qalu_comp_t          own_a_i,
  input  wire qalu_pkg::qalu_comp_t          own_b_i,
  input  wire logic [qalu_pkg::D_W-1:0]      d_i,
  output logic signed [qalu_pkg::ACC_W-1:0]  acc_o,
  output qalu_pkg::qalu_lane_res_t           res_o
);
  import qalu_pkg::*;

  typedef struct packed {
    qalu_cmd_t cmd;
    logic      neg;
    logic      dz;
    logic      ovf;
    qalu_nar_t early;
  } qalu_side_t;

  logic [3:0]              mask;
  logic signed [P_W-1:0]   p_r [4];
  logic signed [CW:0]      lin_r;
  qalu_cmd_t               cmd2_r, cmd3_r, cmd4_r, cmd5_r, cmd6_r;
  logic signed [ACC_W-1:0] s01_r, s23_r, acc_r;
  qalu_nar_t               early3_r, early4_r, early5_r, early6_r;
  logic [CW:0]             lin_mag;
  logic                    neg5_r, neg6_r;
  logic [MAG_W-1:0]        mag5_r;
  logic [D_W-1:0]          d5_r;
  logic [MAG_W:0]          rsum;
  logic [NUM_W-1:0]        num6_r;
  logic [MR_W-1:0]         mr6_r;
  logic [DEN_W-1:0]        den6_r, rem7_r, den7_r;
  logic                    dz6_r;
  logic [STEPS-1:0]        low7_r, q;
  qalu_side_t              side7_r;
  qalu_side_t              side_r [STEPS];
  qalu_side_t              side_l;
  qalu_nar_t               nq;
  qalu_lane_res_t          res_nxt, res_r;

  // Pick subtract pattern for this operation
  always_comb begin
    case (cmd_i)
      CMD_MUL: mask = cfg_i.mul_neg;
      CMD_DIV: mask = cfg_i.div_neg;
      default: mask = 4'b0000;
    endcase
  end

  // Signed products and the element-wise operations
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (mask[k]) p_r[k] <= P_W'(-((CW+1)'(a_i[k]))) * P_W'(b_i[k]);
      else         p_r[k] <= P_W'((CW+1)'(a_i[k])) * P_W'(b_i[k]);
    end
    case (cmd_i)
      CMD_ADD:  lin_r <= (CW+1)'(own_a_i) + (CW+1)'(own_b_i);
      CMD_SUB:  lin_r <= (CW+1)'(own_a_i) - (CW+1)'(own_b_i);
      CMD_CONJ: lin_r <= cfg_i.conj_neg ? -((CW+1)'(own_a_i)) : (CW+1)'(own_a_i);
      default:  lin_r <= '0;
    endcase
    cmd2_r <= cmd_i;
  end

  assign lin_mag = lin_r[CW] ? (CW+1)'(0) - lin_r : lin_r;

  // Pair sums, clamp element-wise result
  always_ff @(posedge clk) begin
    s01_r    <= ACC_W'(p_r[0]) + ACC_W'(p_r[1]);
    s23_r    <= ACC_W'(p_r[2]) + ACC_W'(p_r[3]);
    early3_r <= narrow(NAR_W'(lin_mag), lin_r[CW]);
    cmd3_r   <= cmd2_r;
  end

  // Full sum
  always_ff @(posedge clk) begin
    acc_r    <= s01_r + s23_r;
    early4_r <= early3_r;
    cmd4_r   <= cmd3_r;
  end

  assign acc_o = acc_r;

  // Sign and magnitude
  always_ff @(posedge clk) begin
    neg5_r   <= acc_r[ACC_W-1];
    mag5_r   <= acc_r[ACC_W-1] ? MAG_W'(-acc_r) : MAG_W'(acc_r);
    d5_r     <= d_i;
    early5_r <= early4_r;
    cmd5_r   <= cmd4_r;
  end

  assign rsum = (MAG_W+1)'(mag5_r) + ((MAG_W+1)'(1) << (FRAC_BITS - 1));

  // Rounded product, dividend and divisor
  always_ff @(posedge clk) begin
    num6_r   <= (NUM_W'(mag5_r) << (FRAC_BITS + 1)) + NUM_W'(d5_r);
    mr6_r    <= rsum[MAG_W:FRAC_BITS];
    den6_r   <= DEN_W'(d5_r) << 1;
    dz6_r    <= (d5_r == '0);
    neg6_r   <= neg5_r;
    early6_r <= early5_r;
    cmd6_r   <= cmd5_r;
  end

  // Overflow check and divider load
  always_ff @(posedge clk) begin
    rem7_r        <= DEN_W'(num6_r >> (CW + 1));
    low7_r        <= num6_r[CW:0];
    den7_r        <= den6_r;
    side7_r.cmd   <= cmd6_r;
    side7_r.neg   <= neg6_r;
    side7_r.dz    <= dz6_r;
    side7_r.ovf   <= ((num6_r >> (CW + 1)) >= NUM_W'(den6_r));
    side7_r.early <= (cmd6_r == CMD_MUL) ? narrow(NAR_W'(mr6_r), neg6_r) : early6_r;
  end

  qalu_div u_div (
    .clk   (clk),
    .rem_i (rem7_r),
    .low_i (low7_r),
    .den_i (den7_r),
    .q_o   (q)
  );

  // Hold side data alongside the divider
  always_ff @(posedge clk) begin
    side_r[0] <= side7_r;
    for (int j = 1; j < STEPS; j++) side_r[j] <= side_r[j-1];
  end

  // Final clamp and select
  always_comb begin
    side_l  = side_r[STEPS-1];
    nq      = narrow(side_l.ovf ? {NAR_W{1'b1}} : NAR_W'(q), side_l.neg);
    res_nxt = '0;
    case (side_l.cmd)
      CMD_DIV: begin
        if (side_l.dz) begin
          res_nxt.dz = 1'b1;
        end else begin
          res_nxt.sat = nq.sat;
          res_nxt.val = nq.val;
        end
      end
      CMD_ADD, CMD_SUB, CMD_CONJ, CMD_MUL: begin
        res_nxt.sat = side_l.early.sat;
        res_nxt.val = side_l.early.val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

`default_nettype wire

// ===== hdl/qalu_sqrt.sv =====
// Squared magnitude rounding and pipelined integer square root, one root bit
// per stage. Depends on qalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qalu_sqrt (
  input  wire logic                            clk,
  input  wire logic signed [qalu_pkg::ACC_W-1:0] s_i,
  output logic [qalu_pkg::SCALAR_W-1:0]        sqm_o,
  output logic                                 sqm_sat_o,
  output logic [qalu_pkg::SCALAR_W-1:0]        root_o
);
  import qalu_pkg::*;

  localparam int SQC_W = (MR_W > SCALAR_W) ? MR_W : SCALAR_W + 1;

  logic [MAG_W-1:0]    s5_r, s6_r, e7_r;
  logic [MAG_W:0]      rsum;
  logic [MR_W-1:0]     sqr6_r;
  logic [SCALAR_W-1:0] sqm7_r;
  logic                sat7_r;
  logic [MAG_W-1:0]    e_r   [STEPS];
  logic [STEPS-1:0]    r_r   [STEPS];
  logic [SCALAR_W-1:0] sqm_r [STEPS];
  logic                sat_r [STEPS];
  logic [SCALAR_W-1:0] root_nxt;
  logic [SCALAR_W-1:0] sqm_out_r, root_r;
  logic                sat_out_r;

  // Take the sum of squares
  always_ff @(posedge clk) begin
    s5_r <= s_i[MAG_W-1:0];
  end

  assign rsum = (MAG_W+1)'(s5_r) + ((MAG_W+1)'(1) << (FRAC_BITS - 1));

  // Round squared magnitude
  always_ff @(posedge clk) begin
    s6_r   <= s5_r;
    sqr6_r <= rsum[MAG_W:FRAC_BITS];
  end

  // Saturate squared magnitude
  always_ff @(posedge clk) begin
    e7_r   <= s6_r;
    sat7_r <= (SQC_W'(sqr6_r) > SQC_W'(SCALAR_MAX));
    sqm7_r <= (SQC_W'(sqr6_r) > SQC_W'(SCALAR_MAX)) ? SCALAR_MAX : SCALAR_W'(sqr6_r);
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int BI = CW - j;
    logic [MAG_W-1:0]    e_p;
    logic [STEPS-1:0]    r_p;
    logic [SCALAR_W-1:0] sqm_p;
    logic                sat_p;
    logic [T_W-1:0]      trial;
    logic                take;

    if (j == 0) begin : g_first
      assign e_p   = e7_r;
      assign r_p   = '0;
      assign sqm_p = sqm7_r;
      assign sat_p = sat7_r;
    end else begin : g_next
      assign e_p   = e_r[j-1];
      assign r_p   = r_r[j-1];
      assign sqm_p = sqm_r[j-1];
      assign sat_p = sat_r[j-1];
    end

    // Trial (r + 2^i)^2 - r^2 against the residual
    assign trial = (T_W'(r_p) << (BI + 1)) | (T_W'(1) << (2 * BI));
    assign take  = (T_W'(e_p) >= trial);

    always_ff @(posedge clk) begin
      e_r[j]   <= take ? MAG_W'(T_W'(e_p) - trial) : e_p;
      r_r[j]   <= take ? (r_p | (STEPS'(1) << BI)) : r_p;
      sqm_r[j] <= sqm_p;
      sat_r[j] <= sat_p;
    end
  end

  // Round the root to nearest
  assign root_nxt = (e_r[STEPS-1] > MAG_W'(r_r[STEPS-1])) ?
                    SCALAR_W'(r_r[STEPS-1]) + SCALAR_W'(1) : SCALAR_W'(r_r[STEPS-1]);

  always_ff @(posedge clk) begin
    root_r    <= root_nxt;
    sqm_out_r <= sqm_r[STEPS-1];
    sat_out_r <= sat_r[STEPS-1];
  end

  assign sqm_o     = sqm_out_r;
  assign sqm_sat_o = sat_out_r;
  assign root_o    = root_r;

endmodule

`default_nettype wire

// ===== hdl/quaternion_alu.sv =====
// Quaternion ALU top level: input register, four component lanes, norm
// pipeline, square root unit and result merge. Depends on qalu_pkg,
// qalu_lane, qalu_div and qalu_sqrt.
// The result strobe follows the start transfer through the input register,
// the lane pipeline and the output register, with one divider or root stage
// per result bit. Throughput: one operation per cycle, busy only in reset.
// Reset (synchronous, rst_n low) clears the valid pipeline and strobe.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_alu (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    in_cmd,
  input  wire logic [qalu_pkg::IO_W-1:0]     in_a_w,
  input  wire logic [qalu_pkg::IO_W-1:0]     in_a_x,
  input  wire logic [qalu_pkg::IO_W-1:0]     in_a_y,
  input  wire logic [qalu_pkg::IO_W-1:0]     in_a_z,
  input  wire logic [qalu_pkg::IO_W-1:0]     in_b_w,
  input  wire logic [qalu_pkg::IO_W-1:0]     in_b_x,
  input  wire logic [qalu_pkg::IO_W-1:0]     in_b_y,
  input  wire logic [qalu_pkg::IO_W-1:0]     in_b_z,
  output logic                               out_strobe,
  output logic [qalu_pkg::IO_W-1:0]          out_r_w,
  output logic [qalu_pkg::IO_W-1:0]          out_r_x,
  output logic [qalu_pkg::IO_W-1:0]          out_r_y,
  output logic [qalu_pkg::IO_W-1:0]          out_r_z,
  output logic [qalu_pkg::SCALAR_W-1:0]      out_scalar_out,
  output logic [1:0]                         out_status
);
  import qalu_pkg::*;

  logic                    busy_r;
  logic                    v_pipe_r   [LAT];
  qalu_cmd_t               cmd_pipe_r [LAT];
  qalu_comp_t              a1_r [4];
  qalu_comp_t              b1_r [4];
  qalu_comp_t              mb   [4];
  qalu_comp_t              lane_b [4][4];
  logic [SQ_W-1:0]         bsq_r [4];
  logic [D_W-1:0]          dp_r [2];
  logic [D_W-1:0]          d_r;
  logic signed [ACC_W-1:0] lane_acc [4];
  qalu_lane_res_t          lane_res [4];
  logic [SCALAR_W-1:0]     sqm, root;
  logic                    sqm_sat;
  qalu_cmd_t               cmd_l;
  logic [IO_W-1:0]         r_nxt [4];
  logic [IO_W-1:0]         r_r   [4];
  logic [SCALAR_W-1:0]     scal_nxt, scal_r;
  qalu_status_t            status_nxt, status_r;
  logic                    out_strobe_r;

  // Always ready outside reset
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  assign busy = busy_r;

  // Valid and opcode pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) v_pipe_r[k] <= 1'b0;
    end else begin
      v_pipe_r[0] <= start && !busy_r;
      for (int k = 1; k < LAT; k++) v_pipe_r[k] <= v_pipe_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    cmd_pipe_r[0] <= qalu_cmd_t'(in_cmd);
    for (int k = 1; k < LAT; k++) cmd_pipe_r[k] <= cmd_pipe_r[k-1];
  end

  // Capture the operands of a transfer
  always_ff @(posedge clk) begin
    a1_r[0] <= $signed(in_a_w[CW-1:0]);
    a1_r[1] <= $signed(in_a_x[CW-1:0]);
    a1_r[2] <= $signed(in_a_y[CW-1:0]);
    a1_r[3] <= $signed(in_a_z[CW-1:0]);
    b1_r[0] <= $signed(in_b_w[CW-1:0]);
    b1_r[1] <= $signed(in_b_x[CW-1:0]);
    b1_r[2] <= $signed(in_b_y[CW-1:0]);
    b1_r[3] <= $signed(in_b_z[CW-1:0]);
  end

  // Magnitude operations square a against itself
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mb[k] = (cmd_pipe_r[0] == CMD_SQMAG || cmd_pipe_r[0] == CMD_MAG) ? a1_r[k] : b1_r[k];
    end
  end

  // Norm of b for division
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) bsq_r[k] <= SQ_W'(b1_r[k]) * SQ_W'(b1_r[k]);
    dp_r[0] <= D_W'(bsq_r[0]) + D_W'(bsq_r[1]);
    dp_r[1] <= D_W'(bsq_r[2]) + D_W'(bsq_r[3]);
    d_r     <= dp_r[0] + dp_r[1];
  end

  // Lane L pairs a[k] with b[k xor L]
  for (genvar L = 0; L < 4; L++) begin : g_lane
    for (genvar k = 0; k < 4; k++) begin : g_perm
      assign lane_b[L][k] = mb[L ^ k];
    end

    qalu_lane u_lane (
      .clk     (clk),
      .cmd_i   (cmd_pipe_r[0]),
      .cfg_i   (LANE_CFG[L]),
      .a_i     (a1_r),
      .b_i     (lane_b[L]),
      .own_a_i (a1_r[L]),
      .own_b_i (b1_r[L]),
      .d_i     (d_r),
      .acc_o   (lane_acc[L]),
      .res_o   (lane_res[L])
    );
  end

  qalu_sqrt u_sqrt (
    .clk       (clk),
    .s_i       (lane_acc[0]),
    .sqm_o     (sqm),
    .sqm_sat_o (sqm_sat),
    .root_o    (root)
  );

  // Merge lane and scalar results
  always_comb begin
    cmd_l = cmd_pipe_r[LAT-1];
    for (int k = 0; k < 4; k++) r_nxt[k] = IO_W'($signed(lane_res[k].val));
    case (cmd_l)
      CMD_SQMAG: scal_nxt = sqm;
      CMD_MAG:   scal_nxt = root;
      default:   scal_nxt = '0;
    endcase
    if (cmd_l == CMD_DIV && lane_res[0].dz) begin
      status_nxt = ST_DZ;
    end else if (lane_res[0].sat || lane_res[1].sat || lane_res[2].sat || lane_res[3].sat ||
                 (cmd_l == CMD_SQMAG && sqm_sat)) begin
      status_nxt = ST_SAT;
    end else begin
      status_nxt = ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= v_pipe_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) r_r[k] <= r_nxt[k];
    scal_r   <= scal_nxt;
    status_r <= status_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_r_w        = r_r[0];
  assign out_r_x        = r_r[1];
  assign out_r_y        = r_r[2];
  assign out_r_z        = r_r[3];
  assign out_scalar_out = scal_r;
  assign out_status     = status_r;

endmodule

`default_nettype wire

// ===== bench/quaternion_alu_test.sv =====
// Self-checking bench for quaternion_alu: directed and random operations,
// with expected results computed by an internal wide-arithmetic predictor.
// Depends on qalu_pkg and quaternion_alu.
`timescale 1ns / 1ps

module quaternion_alu_test;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] a [4];
    logic [31:0] b [4];
  } op_t;

  typedef struct {
    logic [31:0] r [4];
    logic [47:0] scalar;
    logic [1:0]  status;
  } res_t;

  localparam int IDLE_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_cmd;
  logic [31:0] in_a_w, in_a_x, in_a_y, in_a_z;
  logic [31:0] in_b_w, in_b_x, in_b_y, in_b_z;
  logic        out_strobe;
  logic [31:0] out_r_w, out_r_x, out_r_y, out_r_z;
  logic [47:0] out_scalar_out;
  logic [1:0]  out_status;

  op_t  pending_ops [$];
  res_t expected_results [$];
  op_t  cur_op;
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   burst_left = 0;
  int   gap_left = 0;

  quaternion_alu DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd),
    .in_a_w(in_a_w), .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_w(in_b_w), .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .out_strobe(out_strobe),
    .out_r_w(out_r_w), .out_r_x(out_r_x), .out_r_y(out_r_y), .out_r_z(out_r_z),
    .out_scalar_out(out_scalar_out), .out_status(out_status)
  );

  // 12 ns clock
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // Clamp a sign and magnitude to the 32-bit component range
  function automatic logic [31:0] clamp_comp(input wide_t mag, input logic neg,
                                             inout logic sat);
    wide_t lim;
    lim = neg ? (wide_t'(1) <<< 31) : ((wide_t'(1) <<< 31) - 1);
    if (mag > lim) begin
      sat = 1'b1;
      mag = lim;
    end
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  function automatic logic [31:0] clamp_signed(input wide_t v, inout logic sat);
    return (v < 0) ? clamp_comp(-v, 1'b1, sat) : clamp_comp(v, 1'b0, sat);
  endfunction

  // Round a product sum with 32 fraction bits to 16
  function automatic logic [31:0] round_product(input wide_t acc, inout logic sat);
    wide_t mag;
    mag = (acc < 0) ? -acc : acc;
    mag = (mag + (wide_t'(1) <<< 15)) >>> 16;
    return clamp_comp(mag, acc < 0, sat);
  endfunction

  // Rounded acc / norm with 16 fraction bits
  function automatic logic [31:0] round_quotient(input wide_t acc, input wide_t norm,
                                                 inout logic sat);
    wide_t mag;
    mag = (acc < 0) ? -acc : acc;
    mag = ((mag <<< 17) + norm) / (norm <<< 1);
    return clamp_comp(mag, acc < 0, sat);
  endfunction

  // Expected result of one quaternion operation
  function automatic res_t quat_predict(input op_t op);
    res_t  res;
    wide_t a [4];
    wide_t b [4];
    wide_t t [4];
    wide_t sa, sb, d, root, c;
    logic  sat;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      a[i] = wide_t'($signed(op.a[i]));
      b[i] = wide_t'($signed(op.b[i]));
      res.r[i] = '0;
    end
    res.scalar = '0;
    res.status = qalu_pkg::ST_OK;
    sa = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
    sb = b[0]*b[0] + b[1]*b[1] + b[2]*b[2] + b[3]*b[3];
    case (op.cmd)
      qalu_pkg::CMD_ADD:
        for (int i = 0; i < 4; i++) res.r[i] = clamp_signed(a[i] + b[i], sat);
      qalu_pkg::CMD_SUB:
        for (int i = 0; i < 4; i++) res.r[i] = clamp_signed(a[i] - b[i], sat);
      qalu_pkg::CMD_MUL: begin
        t[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
        t[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
        t[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
        t[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
        for (int i = 0; i < 4; i++) res.r[i] = round_product(t[i], sat);
      end
      qalu_pkg::CMD_DIV: begin
        if (sb == 0) begin
          res.status = qalu_pkg::ST_DZ;
        end else begin
          t[0] = a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3];
          t[1] = a[1]*b[0] - a[0]*b[1] - a[2]*b[3] + a[3]*b[2];
          t[2] = a[1]*b[3] - a[0]*b[2] + a[2]*b[0] - a[3]*b[1];
          t[3] = a[2]*b[1] - a[0]*b[3] - a[1]*b[2] + a[3]*b[0];
          for (int i = 0; i < 4; i++) res.r[i] = round_quotient(t[i], sb, sat);
        end
      end
      qalu_pkg::CMD_CONJ: begin
        res.r[0] = op.a[0];
        for (int i = 1; i < 4; i++) res.r[i] = clamp_signed(-a[i], sat);
      end
      qalu_pkg::CMD_SQMAG: begin
        d = (sa + (wide_t'(1) <<< 15)) >>> 16;
        if (d > ((wide_t'(1) <<< 48) - 1)) begin
          sat = 1'b1;
          res.scalar = '1;
        end else begin
          res.scalar = 48'(d);
        end
      end
      qalu_pkg::CMD_MAG: begin
        root = 0;
        for (int i = 33; i >= 0; i--) begin
          c = root | (wide_t'(1) <<< i);
          if (c * c <= sa) root = c;
        end
        if (sa - root * root > root) root = root + 1;
        res.scalar = 48'(root);
      end
      default: ;
    endcase
    if (res.status == qalu_pkg::ST_OK && sat) res.status = qalu_pkg::ST_SAT;
    return res;
  endfunction

  // Random component: full range, small, extreme, near-limit and zero values
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      7: case ($urandom_range(0, 4))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'h0000_0000;
           3: return 32'hffff_ffff;
           default: return 32'h0001_0000;
         endcase
      8:  return $urandom_range(0, 1) ? 32'h4000_0000 + $urandom_range(0, 255)
                                      : 32'hc000_0000 - $urandom_range(0, 255);
      default: return 32'h0;
    endcase
  endfunction

  function automatic op_t make_op(input logic [2:0] cmd, input logic [31:0] av,
                                  input logic [31:0] bv);
    op_t op;
    op.cmd = cmd;
    for (int i = 0; i < 4; i++) begin
      op.a[i] = av;
      op.b[i] = bv;
    end
    return op;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s at %0t: got %h, expected %h", what, $time, got, want);
    mismatches++;
  endtask

  // Driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start  <= 1'b0;
      in_cmd <= '0;
      in_a_w <= '0; in_a_x <= '0; in_a_y <= '0; in_a_z <= '0;
      in_b_w <= '0; in_b_x <= '0; in_b_y <= '0; in_b_z <= '0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(quat_predict(cur_op));
        idle_cycles = 0;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          cur_op = pending_ops.pop_front();
          in_cmd <= cur_op.cmd;
          in_a_w <= cur_op.a[0]; in_a_x <= cur_op.a[1];
          in_a_y <= cur_op.a[2]; in_a_z <= cur_op.a[3];
          in_b_w <= cur_op.b[0]; in_b_x <= cur_op.b[1];
          in_b_y <= cur_op.b[2]; in_b_z <= cur_op.b[3];
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_strobe) begin
      idle_cycles = 0;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", {32'h0, out_r_w}, 64'h0);
      end else begin
        want = expected_results.pop_front();
        if (out_r_w !== want.r[0]) report_mismatch("r_w", out_r_w, want.r[0]);
        if (out_r_x !== want.r[1]) report_mismatch("r_x", out_r_x, want.r[1]);
        if (out_r_y !== want.r[2]) report_mismatch("r_y", out_r_y, want.r[2]);
        if (out_r_z !== want.r[3]) report_mismatch("r_z", out_r_z, want.r[3]);
        if (out_scalar_out !== want.scalar)
          report_mismatch("scalar_out", out_scalar_out, want.scalar);
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    op_t op;
    logic [2:0] cmd;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = '0;
    in_a_w = '0; in_a_x = '0; in_a_y = '0; in_a_z = '0;
    in_b_w = '0; in_b_x = '0; in_b_y = '0; in_b_z = '0;

    // Directed: every opcode at the extremes
    for (int c = 0; c < 8; c++) begin
      pending_ops.push_back(make_op(3'(c), 32'h7fff_ffff, 32'h7fff_ffff));
      pending_ops.push_back(make_op(3'(c), 32'h8000_0000, 32'h0001_0000));
    end
    // Division by a zero quaternion
    pending_ops.push_back(make_op(qalu_pkg::CMD_DIV, 32'h0003_0000, 32'h0));
    // Rounding ties in the product, both signs
    op = make_op(qalu_pkg::CMD_MUL, 32'h0, 32'h0);
    op.a[0] = 32'h1; op.b[0] = 32'h8000;
    pending_ops.push_back(op);
    op.a[0] = 32'hffff_ffff;
    pending_ops.push_back(op);
    // Conjugate of the most negative vector part saturates
    op = make_op(qalu_pkg::CMD_CONJ, 32'h8000_0000, 32'h0);
    pending_ops.push_back(op);
    // Unit quaternion products and quotients
    op = make_op(qalu_pkg::CMD_MUL, 32'h0, 32'h0);
    op.a[1] = 32'h0001_0000; op.b[2] = 32'h0001_0000;
    pending_ops.push_back(op);
    op.cmd = qalu_pkg::CMD_DIV; op.b[2] = 32'hffff_0000;
    pending_ops.push_back(op);
    pending_ops.push_back(make_op(qalu_pkg::CMD_MAG, 32'h0, 32'h0));

    // Random operations
    for (int n = 0; n < 2000; n++) begin
      cmd = ($urandom_range(0, 40) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      op.cmd = cmd;
      for (int i = 0; i < 4; i++) begin
        op.a[i] = rand_comp();
        op.b[i] = rand_comp();
      end
      if (cmd == qalu_pkg::CMD_DIV && $urandom_range(0, 7) == 0)
        for (int i = 0; i < 4; i++) op.b[i] = '0;
      pending_ops.push_back(op);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all items sent and all results back, then a latency margin
    do @(posedge clk);
    while (pending_ops.size() > 0 || start || expected_results.size() > 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/qalu_pkg.sv
hdl/qalu_div.sv
hdl/qalu_lane.sv
hdl/qalu_sqrt.sv
hdl/quaternion_alu.sv
bench/quaternion_alu_test.sv
